// ----- hdl/imu_packet_deframer_scaler_unit_macros.svh -----
// assertion macros shared by the imu packet deframer and scaler rtl
`ifndef IMU_PACKET_DEFRAMER_SCALER_UNIT_MACROS_SVH
`define IMU_PACKET_DEFRAMER_SCALER_UNIT_MACROS_SVH

// same-cycle implication, checked on the module clock outside reset
`define IPDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on the module clock outside reset
`define IPDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ipds_pkg.sv -----
// shared constants and types for the imu packet deframer and scaler
`timescale 1ns / 1ps
`default_nettype none

package ipds_pkg;

  localparam logic [7:0] HDR_CR    = 8'h0D;
  localparam logic [7:0] HDR_LF    = 8'h0A;
  localparam logic [7:0] HDR_COLON = 8'h3A;

  localparam logic [7:0] OLDER_RESET = 8'd2;
  localparam logic [7:0] NEWER_RESET = 8'd3;

  localparam int STORE_FIRST = 11;
  localparam int STORE_LEN   = 24;
  localparam int POS_W       = 6;
  localparam logic [POS_W-1:0] POS_MAX = 6'd63;

  localparam int RATE_BASE_X  = 0;
  localparam int RATE_BASE_Y  = 4;
  localparam int RATE_BASE_Z  = 8;
  localparam int ACCEL_BASE_X = 12;
  localparam int ACCEL_BASE_Y = 16;
  localparam int ACCEL_BASE_Z = 20;

  localparam logic [9:0] ACCEL_SCALE_EXP = 10'd13;
  localparam logic [9:0] RATE_SCALE_EXP  = 10'd15;
  localparam logic [9:0] EXP_BIAS_SHIFT  = 10'd150;

  localparam int MAG_W       = 25;
  localparam int RECIP_SHIFT = 32;
  localparam int PROD_W      = 2 * MAG_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam logic [MAG_W-1:0] RATE_RECIP    = 25'd17530479;
  localparam logic [MAG_W-1:0] RATE_ROUND_UP = 25'd244;

  localparam logic [15:0] RES_ZERO = 16'h0000;
  localparam logic [15:0] RES_MID  = 16'h8000;
  localparam logic [15:0] RES_MAX  = 16'hFFFF;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld_out;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/imu_packet_deframer_scaler_unit.sv -----
// result: the request that carries the closing 0a byte sets v0, then moves through v1, v2 and res_valid
// throughput: one byte request per cycle, held off only while a finished result is blocked
// the pipeline is store read and align, reciprocal multiply, then offset and saturation
// reset: synchronous, clears framing state to hunting, history to 02 03, store to zeros
`timescale 1ns / 1ps
`default_nettype none
`include "imu_packet_deframer_scaler_unit_macros.svh"

module imu_packet_deframer_scaler_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rx_valid,
  output logic             rx_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [15:0]      accel_x,
  output logic [15:0]      accel_y,
  output logic [15:0]      accel_z,
  output logic [15:0]      rate_x,
  output logic [15:0]      rate_y,
  output logic [15:0]      rate_z
);
  import ipds_pkg::*;

  logic [7:0]       older_byte;
  logic [7:0]       newer_byte;
  logic             in_packet;
  logic [POS_W-1:0] byte_position;
  logic [7:0]       payload_store [STORE_LEN];

  logic             v0;
  logic             v1;
  logic             v2;

  logic             accept;
  logic             is_hdr;
  logic             is_end;
  logic             pos_step;
  logic [POS_W-1:0] pos_inc;

  logic             out_free;
  logic             s2_free;
  logic             s1_free;
  lane_ctl_t        ctl;

  assign is_hdr   = !in_packet && older_byte == HDR_CR && newer_byte == HDR_LF
                    && rx_byte == HDR_COLON;
  assign is_end   = in_packet && newer_byte == HDR_CR && rx_byte == HDR_LF;
  assign pos_step = byte_position != POS_MAX;
  assign pos_inc  = byte_position + POS_W'(1);

  assign out_free   = !res_valid || res_ready;
  assign s2_free    = !v2 || out_free;
  assign s1_free    = !v1 || s2_free;
  assign ctl.ld_out = v2 && out_free;
  assign ctl.ld2    = v1 && s2_free;
  assign ctl.ld1    = v0 && s1_free;
  // the store must not change while a decode waits on it
  assign rx_ready   = !v0 || s1_free;
  assign accept     = rx_valid && rx_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      older_byte    <= OLDER_RESET;
      newer_byte    <= NEWER_RESET;
      in_packet     <= 1'b0;
      byte_position <= '0;
      for (int i = 0; i < STORE_LEN; i++) begin
        payload_store[i] <= 8'd0;
      end
    end else if (accept) begin
      older_byte <= newer_byte;
      newer_byte <= rx_byte;
      if (in_packet && pos_step) begin
        for (int i = 0; i < STORE_LEN; i++) begin
          if (pos_inc == POS_W'(STORE_FIRST + i)) begin
            payload_store[i] <= rx_byte;
          end
        end
      end
      if (is_hdr) begin
        in_packet     <= 1'b1;
        byte_position <= '0;
      end else if (is_end) begin
        in_packet     <= 1'b0;
        byte_position <= '0;
      end else if (in_packet && pos_step) begin
        byte_position <= pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v0        <= (accept && is_end) || (v0 && !ctl.ld1);
      v1        <= ctl.ld1 || (v1 && !ctl.ld2);
      v2        <= ctl.ld2 || (v2 && !ctl.ld_out);
      res_valid <= ctl.ld_out || (res_valid && !res_ready);
    end
  end

  ipds_conv u_accel_x (
    .clk(clk), .rst(rst), .ctl(ctl), .rate_lane(1'b0),
    .word({payload_store[ACCEL_BASE_X+3], payload_store[ACCEL_BASE_X+2],
           payload_store[ACCEL_BASE_X+1], payload_store[ACCEL_BASE_X]}),
    .res(accel_x)
  );

  ipds_conv u_accel_y (
    .clk(clk), .rst(rst), .ctl(ctl), .rate_lane(1'b0),
    .word({payload_store[ACCEL_BASE_Y+3], payload_store[ACCEL_BASE_Y+2],
           payload_store[ACCEL_BASE_Y+1], payload_store[ACCEL_BASE_Y]}),
    .res(accel_y)
  );

  ipds_conv u_accel_z (
    .clk(clk), .rst(rst), .ctl(ctl), .rate_lane(1'b0),
    .word({payload_store[ACCEL_BASE_Z+3], payload_store[ACCEL_BASE_Z+2],
           payload_store[ACCEL_BASE_Z+1], payload_store[ACCEL_BASE_Z]}),
    .res(accel_z)
  );

  ipds_conv u_rate_x (
    .clk(clk), .rst(rst), .ctl(ctl), .rate_lane(1'b1),
    .word({payload_store[RATE_BASE_X+3], payload_store[RATE_BASE_X+2],
           payload_store[RATE_BASE_X+1], payload_store[RATE_BASE_X]}),
    .res(rate_x)
  );

  ipds_conv u_rate_y (
    .clk(clk), .rst(rst), .ctl(ctl), .rate_lane(1'b1),
    .word({payload_store[RATE_BASE_Y+3], payload_store[RATE_BASE_Y+2],
           payload_store[RATE_BASE_Y+1], payload_store[RATE_BASE_Y]}),
    .res(rate_y)
  );

  ipds_conv u_rate_z (
    .clk(clk), .rst(rst), .ctl(ctl), .rate_lane(1'b1),
    .word({payload_store[RATE_BASE_Z+3], payload_store[RATE_BASE_Z+2],
           payload_store[RATE_BASE_Z+1], payload_store[RATE_BASE_Z]}),
    .res(rate_z)
  );

  `IPDS_ASSERT_NOW(a_hunt_pos_zero, !in_packet, byte_position == '0, "position nonzero while hunting")
  `IPDS_ASSERT_NOW(a_decode_while_hunting, v0, !in_packet, "decode pending inside a packet")
  `IPDS_ASSERT_NEXT(a_result_loaded, v2 && out_free, res_valid, "finished result not presented")

endmodule

`default_nettype wire

// ----- hdl/ipds_conv.sv -----
// one conversion lane: ieee single to saturated offset-binary 16-bit value
`timescale 1ns / 1ps
`default_nettype none
`include "imu_packet_deframer_scaler_unit_macros.svh"

module ipds_conv (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ipds_pkg::lane_ctl_t ctl,
  input  wire logic              rate_lane,
  input  wire logic [31:0]       word,
  output logic [15:0]            res
);
  import ipds_pkg::*;

  logic             neg;
  logic [7:0]       ex;
  logic [22:0]      man;
  logic [23:0]      mant;
  logic [7:0]       eff;
  logic [9:0]       k;
  logic [9:0]       s;
  logic [47:0]      shl;
  logic [23:0]      fl;
  logic             sticky;
  logic [MAG_W-1:0] ce;
  logic [MAG_W-1:0] mag_next;
  logic             force_next;
  logic [15:0]      fval_next;

  logic             neg1;
  logic             force1;
  logic [15:0]      fval1;
  logic [MAG_W-1:0] mag1;

  logic [PROD_W-1:0] prod;
  logic             neg2;
  logic             force2;
  logic [15:0]      fval2;
  logic [MAG_W-1:0] q2;

  logic [15:0]      res_next;
  logic [16:0]      diff;

  // field decode and alignment
  always_comb begin
    neg  = word[31];
    ex   = word[30:23];
    man  = word[22:0];
    mant = {ex != 8'd0, man};
    eff  = (ex == 8'd0) ? 8'd1 : ex;
    k    = {2'b00, eff} + (rate_lane ? RATE_SCALE_EXP : ACCEL_SCALE_EXP) - EXP_BIAS_SHIFT;
    s    = 10'd0 - k;
    shl  = {24'd0, mant} << k[4:0];
    fl     = '0;
    sticky = 1'b0;
    if (!k[9]) begin
      if (k >= 10'd24 || shl[47:24] != 24'd0) begin
        fl = 24'hFFFFFF;
      end else begin
        fl = shl[23:0];
      end
    end else if (s >= 10'd24) begin
      fl     = '0;
      sticky = 1'b1;
    end else begin
      fl     = mant >> s[4:0];
      sticky = (mant & ((24'd1 << s[4:0]) - 24'd1)) != 24'd0;
    end
    ce = {1'b0, fl} + {{(MAG_W-1){1'b0}}, sticky};
    if (!neg) begin
      mag_next = {1'b0, fl};
    end else if (rate_lane) begin
      mag_next = ce + RATE_ROUND_UP;
    end else begin
      mag_next = ce;
    end
    force_next = 1'b0;
    fval_next  = RES_ZERO;
    if (ex == 8'hFF) begin
      force_next = 1'b1;
      fval_next  = (man != 23'd0 || neg) ? RES_ZERO : RES_MAX;
    end else if (mant == 24'd0) begin
      force_next = 1'b1;
      fval_next  = RES_MID;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      neg1   <= neg;
      force1 <= force_next;
      fval1  <= fval_next;
      mag1   <= mag_next;
    end
  end

  // division by the rate full scale as a reciprocal multiply
  assign prod = PROD_W'(mag1) * PROD_W'(RATE_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      neg2   <= neg1;
      force2 <= force1;
      fval2  <= fval1;
      q2     <= rate_lane ? MAG_W'(prod[PROD_W-1:RECIP_SHIFT]) : mag1;
    end
  end

  // offset and saturation
  always_comb begin
    diff = 17'd32768 - q2[16:0];
    if (force2) begin
      res_next = fval2;
    end else if (!neg2) begin
      res_next = (q2 >= MAG_W'(32768)) ? RES_MAX : {1'b1, q2[14:0]};
    end else begin
      res_next = (q2 > MAG_W'(32768)) ? RES_ZERO : diff[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      res <= res_next;
    end
  end

  `IPDS_ASSERT_NEXT(a_pos_not_below_mid, ctl.ld_out && !force2 && !neg2, res >= RES_MID, "positive value below midscale")
  `IPDS_ASSERT_NEXT(a_neg_not_above_mid, ctl.ld_out && !force2 && neg2, res <= RES_MID, "negative value above midscale")
  `IPDS_ASSERT_NEXT(a_forced_value, ctl.ld_out && force2, res == $past(fval2), "special value not forced")

endmodule

`default_nettype wire

// ----- verif/imu_packet_deframer_scaler_unit_tb.sv -----
// self-checking testbench for the imu packet deframer and scaler unit
`timescale 1ns / 1ps

module imu_packet_deframer_scaler_unit_tb;
  import ipds_pkg::*;

  localparam int RATE_DIVISOR       = 245;
  localparam int RANDOM_ITEMS       = 1150;
  localparam int RESULT_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES       = 12;
  localparam int WATCHDOG_LIMIT     = 4000;

  typedef struct packed {
    logic [15:0] accel_x;
    logic [15:0] accel_y;
    logic [15:0] accel_z;
    logic [15:0] rate_x;
    logic [15:0] rate_y;
    logic [15:0] rate_z;
  } imu_sample_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PERIODIC,
    READY_SPARSE
  } ready_mode_t;

  logic        clk;
  logic        rst;
  logic        rx_valid;
  logic        rx_ready;
  logic [7:0]  rx_byte;
  logic        res_valid;
  logic        res_ready;
  logic [15:0] accel_x;
  logic [15:0] accel_y;
  logic [15:0] accel_z;
  logic [15:0] rate_x;
  logic [15:0] rate_y;
  logic [15:0] rate_z;

  imu_packet_deframer_scaler_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .rate_x    (rate_x),
    .rate_y    (rate_y),
    .rate_z    (rate_z)
  );

  // framing model state
  logic [7:0]       hist_older;
  logic [7:0]       hist_newer;
  logic             in_frame;
  logic [POS_W-1:0] frame_pos;
  logic [7:0]       frame_store [STORE_LEN];

  imu_sample_t expected_samples [$];
  int          mismatch_count;
  int          items_sent;
  int          burst_left;
  bit          sender_paced;
  bit          hold_results_req;
  int          idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exact trunc(f * 2^scale_exp / divisor + 32768), saturated to 16 bits
  function automatic logic [15:0] scale_single(logic [31:0] bits, int scale_exp,
                                               longint unsigned divisor);
    logic            neg;
    logic [7:0]      ex;
    logic [22:0]     fr;
    longint unsigned mant;
    longint unsigned lo;
    longint unsigned hi;
    int              k;
    int              s;
    neg = bits[31];
    ex  = bits[30:23];
    fr  = bits[22:0];
    if (ex == 8'hFF) return (fr != 0 || neg) ? RES_ZERO : RES_MAX;
    if (ex == 8'h00) begin
      mant = fr;
      k    = -149;
    end else begin
      mant = {1'b1, fr};
      k    = int'(ex) - 150;
    end
    if (mant == 0) return RES_MID;
    k = k + scale_exp;
    if (k > 20) begin
      lo = 64'd1 << 50;
      hi = lo;
    end else if (k >= 0) begin
      lo = mant << k;
      hi = lo;
    end else if (k <= -40) begin
      lo = 0;
      hi = 1;
    end else begin
      s  = -k;
      lo = mant >> s;
      hi = lo + (((mant & ((64'd1 << s) - 64'd1)) != 0) ? 64'd1 : 64'd0);
    end
    lo = lo / divisor;
    hi = (hi + divisor - 1) / divisor;
    if (!neg) return (lo + 32768 > 65535) ? RES_MAX : 16'(lo + 32768);
    if (hi > 32768) return RES_ZERO;
    return 16'(32768 - hi);
  endfunction

  function automatic logic [31:0] store_word(int base);
    return {frame_store[base + 3], frame_store[base + 2],
            frame_store[base + 1], frame_store[base]};
  endfunction

  function automatic void advance_pos(logic [7:0] b);
    if (frame_pos < POS_MAX) begin
      frame_pos = frame_pos + 1'b1;
      if (frame_pos >= STORE_FIRST && frame_pos < STORE_FIRST + STORE_LEN)
        frame_store[frame_pos - STORE_FIRST] = b;
    end
  endfunction

  function automatic void track_rx_byte(logic [7:0] b);
    imu_sample_t s;
    if (!in_frame) begin
      if (hist_older == HDR_CR && hist_newer == HDR_LF && b == HDR_COLON) begin
        in_frame  = 1'b1;
        frame_pos = '0;
      end
    end else if (hist_newer == HDR_CR && b == HDR_LF) begin
      advance_pos(b);
      s.accel_x = scale_single(store_word(ACCEL_BASE_X), int'(ACCEL_SCALE_EXP), 1);
      s.accel_y = scale_single(store_word(ACCEL_BASE_Y), int'(ACCEL_SCALE_EXP), 1);
      s.accel_z = scale_single(store_word(ACCEL_BASE_Z), int'(ACCEL_SCALE_EXP), 1);
      s.rate_x  = scale_single(store_word(RATE_BASE_X), int'(RATE_SCALE_EXP), RATE_DIVISOR);
      s.rate_y  = scale_single(store_word(RATE_BASE_Y), int'(RATE_SCALE_EXP), RATE_DIVISOR);
      s.rate_z  = scale_single(store_word(RATE_BASE_Z), int'(RATE_SCALE_EXP), RATE_DIVISOR);
      expected_samples.push_back(s);
      in_frame  = 1'b0;
      frame_pos = '0;
    end else begin
      advance_pos(b);
    end
    hist_older = hist_newer;
    hist_newer = b;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    imu_sample_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_samples.size() == 0) begin
        $error("result with no request pending");
        mismatch_count++;
      end else begin
        want = expected_samples.pop_front();
        check_field("accel_x", want.accel_x, accel_x);
        check_field("accel_y", want.accel_y, accel_y);
        check_field("accel_z", want.accel_z, accel_z);
        check_field("rate_x", want.rate_x, rate_x);
        check_field("rate_y", want.rate_y, rate_y);
        check_field("rate_z", want.rate_z, rate_z);
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (rx_valid && rx_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result sink with its own stall pattern
  initial begin : result_sink
    ready_mode_t mode;
    int          mode_left;
    int          phase;
    int          hold_left;
    mode      = READY_ALWAYS;
    mode_left = 0;
    phase     = 0;
    hold_left = 0;
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results_req) begin
        hold_left        = RESULT_HOLD_CYCLES;
        hold_results_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = ready_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        phase++;
        case (mode)
          READY_ALWAYS:   res_ready <= 1'b1;
          READY_RANDOM:   res_ready <= 1'($urandom_range(0, 1));
          READY_PERIODIC: res_ready <= (phase % 7) < 3;
          default:        res_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic idle_rx(input int n);
    repeat (n) begin
      @(negedge clk);
      rx_valid <= 1'b0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (sender_paced) begin
      if (burst_left == 0) begin
        idle_rx($urandom_range(0, 6));
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
    end
    @(negedge clk);
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!rx_ready);
    items_sent++;
    track_rx_byte(b);
  endtask

  task automatic wait_results_drained();
    idle_rx(1);
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_single();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 7))
          0:       return 32'h7FC00000;
          1:       return 32'hFFFFFFFF;
          2:       return 32'h7F800000;
          3:       return 32'hFF800000;
          4:       return 32'h00000000;
          5:       return 32'h80000000;
          6:       return 32'h00000001;
          default: return 32'h807FFFFF;
        endcase
      end
      1:       return $urandom();
      default: return {1'($urandom_range(0, 1)), 8'($urandom_range(100, 136)), 23'($urandom())};
    endcase
  endfunction

  function automatic logic [5:0][31:0] random_words();
    logic [5:0][31:0] w;
    for (int i = 0; i < 6; i++) w[i] = random_single();
    return w;
  endfunction

  // words in store order: rate x, y, z then accel x, y, z
  task automatic send_frame(input int body_len, input logic [5:0][31:0] words);
    logic [7:0] prev;
    logic [7:0] b;
    int         idx;
    send_byte(HDR_CR);
    send_byte(HDR_LF);
    send_byte(HDR_COLON);
    prev = HDR_COLON;
    for (int p = 1; p <= body_len; p++) begin
      if (p >= STORE_FIRST && p < STORE_FIRST + STORE_LEN) begin
        idx = p - STORE_FIRST;
        b   = words[idx / 4][8 * (idx % 4) +: 8];
      end else begin
        b = 8'($urandom());
        if (prev == HDR_CR && b == HDR_LF) b = b ^ 8'h01;
      end
      send_byte(b);
      prev = b;
    end
    send_byte(HDR_CR);
    send_byte(HDR_LF);
  endtask

  task automatic send_noise(input int n);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0:       send_byte(HDR_CR);
        1:       send_byte(HDR_LF);
        2:       send_byte(HDR_COLON);
        default: send_byte(8'($urandom()));
      endcase
    end
  endtask

  // history after reset must not start a frame, and a cleared store reads as zero
  task automatic test_reset_state();
    sender_paced = 1'b0;
    send_byte(HDR_LF);
    send_byte(HDR_COLON);
    send_frame(0, '0);
    wait_results_drained();
  endtask

  task automatic test_special_values();
    sender_paced = 1'b1;
    send_frame(34, {32'h40800000, 32'h00000001, 32'h80000000,
                    32'hFF800000, 32'h7F800000, 32'h7FC00000});
    send_frame(34, {32'h807FFFFF, 32'h7F7FFFFF, 32'hC0800000,
                    32'hB727C5AC, 32'hC3750000, 32'h43750000});
    send_frame(34, {32'h3DCCCCCD, 32'h407FFFFF, 32'hFF7FFFFF,
                    32'h00000000, 32'hBF000000, 32'h3F800000});
  endtask

  // short frames keep stale bytes, long frames saturate the position
  task automatic test_frame_lengths();
    sender_paced = 1'b1;
    send_frame(20, random_words());
    send_frame(11, random_words());
    send_frame(70, random_words());
    send_frame(34, random_words());
    wait_results_drained();
  endtask

  task automatic test_input_backpressure();
    sender_paced     = 1'b0;
    hold_results_req = 1'b1;
    send_byte(HDR_CR);
    send_byte(HDR_LF);
    send_byte(HDR_COLON);
    repeat (40) begin
      send_byte(HDR_CR);
      send_byte(HDR_LF);
      send_byte(HDR_COLON);
    end
    send_byte(HDR_CR);
    send_byte(HDR_LF);
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    int start_items;
    int pick;
    int len;
    start_items = items_sent;
    while ((items_sent - start_items) < RANDOM_ITEMS) begin
      sender_paced = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        case ($urandom_range(0, 9))
          7:       len = $urandom_range(0, 33);
          8:       len = $urandom_range(35, 75);
          9:       len = $urandom_range(0, 75);
          default: len = 34;
        endcase
        send_frame(len, random_words());
      end else if (pick < 18) begin
        send_noise($urandom_range(1, 20));
      end else begin
        send_byte(HDR_CR);
        send_byte(HDR_LF);
        send_byte(HDR_COLON);
        send_noise($urandom_range(0, 40));
      end
      if ($urandom_range(0, 29) == 0) wait_results_drained();
    end
  endtask

  initial begin
    rst              = 1'b1;
    rx_valid         = 1'b0;
    rx_byte          = 8'h00;
    hold_results_req = 1'b0;
    sender_paced     = 1'b0;
    burst_left       = 0;
    mismatch_count   = 0;
    items_sent       = 0;
    idle_cycles      = 0;
    hist_older       = OLDER_RESET;
    hist_newer       = NEWER_RESET;
    in_frame         = 1'b0;
    frame_pos        = '0;
    for (int i = 0; i < STORE_LEN; i++) frame_store[i] = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_special_values();
    test_frame_lengths();
    test_input_backpressure();
    test_random_traffic();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ipds_pkg.sv
hdl/ipds_conv.sv
hdl/imu_packet_deframer_scaler_unit.sv
verif/imu_packet_deframer_scaler_unit_tb.sv
